### sv/float32_minifloat_converter_core_macros.svh
// Assertion macros for the float32/minifloat converter core.
// No dependencies; included by the top level, which provides clk and rst_n.
`ifndef FLOAT32_MINIFLOAT_CONVERTER_CORE_MACROS_SVH
`define FLOAT32_MINIFLOAT_CONVERTER_CORE_MACROS_SVH

// Clocked check, suspended while reset is asserted.
`define FMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication check, suspended while reset is asserted.
`define FMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### sv/fmc_pkg.sv
// Shared types and constants for the float32/minifloat converter core.
// No dependencies; imported by every module of the block.
package fmc_pkg;

  localparam int SGL_FRAC_W = 23;
  localparam int SGL_BIAS   = 127;

  localparam logic [3:0] EXP_W_RESET  = 4'd5;
  localparam logic [4:0] FRAC_W_RESET = 5'd10;
  localparam logic [3:0] EXP_W_MIN    = 4'd2;
  localparam logic [3:0] EXP_W_MAX    = 4'd8;
  localparam logic [4:0] FRAC_W_MIN   = 5'd1;
  localparam logic [4:0] FRAC_W_MAX   = 5'd22;

  typedef enum logic [0:0] {
    CFG_EXP_WIDTH  = 1'b0,
    CFG_FRAC_WIDTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_PACK   = 1'b0,
    KIND_UNPACK = 1'b1
  } kind_t;

  // Effective narrow format, already saturated into range.
  typedef struct packed {
    logic [3:0] e;
    logic [4:0] f;
  } fmt_t;

endpackage

### sv/fmc_cfg.sv
// Format registers of the converter and their saturation into legal range.
// Depends on fmc_pkg.
module fmc_cfg
  import fmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  output fmt_t       fmt
);

  logic [3:0] exp_width_r;
  logic [4:0] frac_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_width_r  <= EXP_W_RESET;
      frac_width_r <= FRAC_W_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXP_WIDTH:  exp_width_r  <= cfg_data[3:0];
        CFG_FRAC_WIDTH: frac_width_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (exp_width_r < EXP_W_MIN) begin
      fmt.e = EXP_W_MIN;
    end else if (exp_width_r > EXP_W_MAX) begin
      fmt.e = EXP_W_MAX;
    end else begin
      fmt.e = exp_width_r;
    end
    if (frac_width_r < FRAC_W_MIN) begin
      fmt.f = FRAC_W_MIN;
    end else if (frac_width_r > FRAC_W_MAX) begin
      fmt.f = FRAC_W_MAX;
    end else begin
      fmt.f = frac_width_r;
    end
  end

endmodule

### sv/fmc_pack.sv
// Single-precision to narrow code: half-up rounding, rebias, flush and saturate.
// Depends on fmc_pkg.
module fmc_pack
  import fmc_pkg::*;
(
  input  fmt_t        fmt,
  input  logic [31:0] operand_bits,
  output logic [31:0] packed_bits
);

  logic [4:0]         rsh;
  logic [22:0]        sig;
  logic [22:0]        half;
  logic               carry;
  logic [22:0]        rsig;
  logic [8:0]         ex_rnd;
  logic [7:0]         bias_n;
  logic signed [10:0] ex_nb;
  logic [8:0]         ex_lim;
  logic [4:0]         sign_pos;
  logic [31:0]        sign_w;

  always_comb begin
    rsh      = 5'(SGL_FRAC_W - 1) - fmt.f;
    sig      = operand_bits[22:0] >> rsh;
    half     = (sig >> 1) + {22'd0, sig[0]};
    carry    = half[fmt.f];
    rsig     = carry ? 23'd0 : half;
    ex_rnd   = {1'b0, operand_bits[30:23]} + {8'd0, carry};
    bias_n   = (8'd1 << (fmt.e - 4'd1)) - 8'd1;
    ex_nb    = signed'({2'b00, ex_rnd}) - 11'(SGL_BIAS) + signed'({3'b000, bias_n});
    ex_lim   = 9'd1 << fmt.e;
    sign_pos = {1'b0, fmt.e} + fmt.f;
    sign_w   = {31'd0, operand_bits[31]} << sign_pos;

    if (ex_nb < 11'sd0 || (ex_nb == 11'sd0 && rsig == 23'd0)) begin
      packed_bits = sign_w;
    end else if (ex_nb >= signed'({2'b00, ex_lim})) begin
      packed_bits = sign_w | ({23'd0, ex_lim - 9'd1} << fmt.f)
                  | ((32'd1 << fmt.f) - 32'd1);
    end else begin
      packed_bits = sign_w | ({24'd0, ex_nb[7:0]} << fmt.f) | {9'd0, rsig};
    end
  end

endmodule

### sv/fmc_unpack.sv
// Narrow code to single precision: mask, rebias, left-align the significand.
// Depends on fmc_pkg.
module fmc_unpack
  import fmc_pkg::*;
(
  input  fmt_t        fmt,
  input  logic [31:0] operand_bits,
  output logic [31:0] unpacked_bits
);

  logic [4:0]  sign_pos;
  logic        sign;
  logic [31:0] sig_w;
  logic [31:0] ex_w;
  logic [7:0]  bias_n;
  logic [7:0]  ex_sgl;
  logic [22:0] sig_al;

  always_comb begin
    sign_pos = {1'b0, fmt.e} + fmt.f;
    sign     = operand_bits[sign_pos];
    sig_w    = operand_bits & ((32'd1 << fmt.f) - 32'd1);
    ex_w     = (operand_bits >> fmt.f) & ((32'd1 << fmt.e) - 32'd1);
    bias_n   = (8'd1 << (fmt.e - 4'd1)) - 8'd1;
    ex_sgl   = ex_w[7:0] + 8'(SGL_BIAS) - bias_n;
    sig_al   = sig_w[22:0] << (5'(SGL_FRAC_W) - fmt.f);

    if (ex_w == 32'd0 && sig_w == 32'd0) begin
      unpacked_bits = {sign, 31'd0};
    end else begin
      unpacked_bits = {sign, ex_sgl, sig_al};
    end
  end

endmodule

### sv/float32_minifloat_converter_core.sv
// Top level of the float32/minifloat converter: input register, conversion, result register.
// Depends on fmc_pkg, fmc_cfg, fmc_pack, fmc_unpack and the core macros header.
//
//   Channel  Direction  Handshake             Payload
//   in       in         in_valid / in_ready   in_kind, in_operand_bits
//   out      out        out_valid / out_ready out_converted_bits
//   cfg      in         cfg_we (no wait)      cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready is held high.
// A transaction passes the input register, one pass of logic, and then the result register.
// Synchronous active-low reset empties both stages and restores the format registers.
// A stalled result holds while the input stage, if empty, still takes one more transaction.
`include "float32_minifloat_converter_core_macros.svh"

module float32_minifloat_converter_core
  import fmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_converted_bits,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  fmt_t        fmt;
  logic        s0_v_r, s0_v_nxt;
  kind_t       s0_kind_r;
  logic [31:0] s0_bits_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_bits_r;
  logic        in_acc;
  logic        s1_load;
  logic [31:0] packed_bits;
  logic [31:0] unpacked_bits;

  fmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fmt       (fmt)
  );

  fmc_pack u_pack (
    .fmt          (fmt),
    .operand_bits (s0_bits_r),
    .packed_bits  (packed_bits)
  );

  fmc_unpack u_unpack (
    .fmt           (fmt),
    .operand_bits  (s0_bits_r),
    .unpacked_bits (unpacked_bits)
  );

  always_comb begin
    s1_load       = !out_valid_r || out_ready;
    in_ready      = !s0_v_r || s1_load;
    in_acc        = in_valid && in_ready;
    s0_v_nxt      = in_acc ? 1'b1 : (s1_load ? 1'b0 : s0_v_r);
    out_valid_nxt = s1_load ? s0_v_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_v_r      <= s0_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_kind_r <= kind_t'(in_kind);
      s0_bits_r <= in_operand_bits;
    end
    if (s1_load && s0_v_r) begin
      out_bits_r <= (s0_kind_r == KIND_UNPACK) ? unpacked_bits : packed_bits;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_converted_bits = out_bits_r;

  `FMC_ASSERT_IMPL(a_ready_follows_out, out_ready, in_ready, "input stalled while output free")
  `FMC_ASSERT(a_in_to_s0, (in_valid && in_ready) |=> s0_v_r, "accepted transaction lost")
  `FMC_ASSERT(a_s0_to_out, (s0_v_r && (!out_valid_r || out_ready)) |=> out_valid_r, "result not registered")
  `FMC_ASSERT_IMPL(a_fmt_range, 1'b1, fmt.e >= EXP_W_MIN && fmt.e <= EXP_W_MAX && fmt.f >= FRAC_W_MIN && fmt.f <= FRAC_W_MAX, "format out of range")

endmodule
